// ===== sv/ising_metropolis_spin_update_macros.svh =====
// Assertion macros for the Ising Metropolis spin update block
`ifndef ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define IMS_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
	else $error("assertion failed: forbidden condition");
`define IMS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("assertion failed: implication");
`else
`define IMS_ASSERT_NEVER(lbl, ck, rn, cond)
`define IMS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== sv/ims_pkg.sv =====
// Types and constants for the Ising Metropolis spin update block
package ims_pkg;
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_FLIP = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [1:0] REG_TEMPERATURE = 2'd0;
	localparam logic [1:0] REG_FIELD       = 2'd1;

	localparam logic [14:0] TEMP_RESET = 15'd4096;
	localparam logic [31:0] RECIP_THREE = 32'hAAAA_AAAB;
	localparam int          DIV_STEPS = 20;
	localparam int          SQ_STEPS = 8;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  site_col;
		logic [6:0]  site_row;
		logic [15:0] random_fraction;
		logic        load_spin;
	} in_t;

	typedef struct packed {
		logic spin_now;
		logic flipped;
	} out_t;
endpackage

// ===== sv/ims_mul.sv =====
// Shared 32x32 multiplier with registered product
module ims_mul import ims_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= {32'd0, a} * {32'd0, b};
	end
endmodule

// ===== sv/ims_lattice.sv =====
// Spin lattice memory, one row per word, registered read
module ims_lattice import ims_pkg::*; #(
	parameter int W = 160,
	parameter int H = 120,
	parameter int RW = 7
) (
	input  logic          clk,
	input  logic [RW-1:0] raddr,
	input  logic          we,
	input  logic [RW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata_q
);
	logic [W-1:0] mem [H];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end
endmodule

// ===== sv/ising_metropolis_spin_update.sv =====
// Sequence: accept, modulo pass, reads of the centre, upper and lower rows, evaluate and write
// for load, read and flips decided without exp, with a further modulo pass per subtraction when
// a coordinate is out of range. An attempt that needs exp adds 20 divider steps, the polynomial
// states M1, M2, M3 and P, repeated squaring and a compare before the write. A new request is taken
// only after the last is written; a stalled output holds the next one off. Reset: asynchronous,
// then a clearing pass over the lattice rows during which no request is taken.
module ising_metropolis_spin_update import ims_pkg::*; #(
	parameter int LATTICE_WIDTH = 160,
	parameter int LATTICE_HEIGHT = 120
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);
`include "ising_metropolis_spin_update_macros.svh"
	localparam int CW = $clog2(LATTICE_WIDTH);
	localparam int RW = $clog2(LATTICE_HEIGHT);
	localparam int CXW = (CW > 8) ? CW : 8;
	localparam int RXW = (RW > 7) ? RW : 7;
	localparam logic [CXW:0] WV = (CXW+1)'(LATTICE_WIDTH);
	localparam logic [RXW:0] HV = (RXW+1)'(LATTICE_HEIGHT);
	localparam logic [CW-1:0] CMAX = CW'(LATTICE_WIDTH - 1);
	localparam logic [RW-1:0] RMAX = RW'(LATTICE_HEIGHT - 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_MOD  = 4'd2;
	localparam logic [3:0] ST_RDC  = 4'd3;
	localparam logic [3:0] ST_RDU  = 4'd4;
	localparam logic [3:0] ST_RDD  = 4'd5;
	localparam logic [3:0] ST_EVAL = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_M1   = 4'd8;
	localparam logic [3:0] ST_M2   = 4'd9;
	localparam logic [3:0] ST_M3   = 4'd10;
	localparam logic [3:0] ST_P    = 4'd11;
	localparam logic [3:0] ST_SQ   = 4'd12;
	localparam logic [3:0] ST_SQW  = 4'd13;
	localparam logic [3:0] ST_CMP  = 4'd14;
	localparam logic [3:0] ST_WR   = 4'd15;

	logic [3:0]     state_q;
	logic [RW-1:0]  clr_q;
	logic [CXW-1:0] col_q;
	logic [RXW-1:0] row_q;
	logic [1:0]     act_q;
	logic [15:0]    rnd_q;
	logic           ld_q;
	logic [14:0]    temp_q;
	logic [14:0]    field_q;
	logic [LATTICE_WIDTH-1:0] rowd_q;
	logic           up_q;
	logic           flip_q;
	logic [15:0]    rem_q;
	logic [19:0]    nb_q;
	logic [19:0]    x_q;
	logic [4:0]     cnt_q;
	logic [31:0]    y2_q;
	logic [31:0]    p_q;
	out_t           out_q;
	logic           out_valid_q;

	logic [CW-1:0]  col_w, lc, rc;
	logic [RW-1:0]  row_w, ur, dr, raddr, waddr;
	logic           we;
	logic [LATTICE_WIDTH-1:0] wdata, rdata;
	logic [31:0]    mul_a, mul_b;
	logic [63:0]    prod;
	logic           s_bit, dn_bit;
	logic [2:0]     nneg;
	logic signed [3:0]  sum;
	logic signed [18:0] e_val, h2, cterm;
	logic [14:0]    tabs;
	logic           t_neg;
	logic [27:0]    y;
	logic [32:0]    p_new;
	logic [16:0]    rem_sh;
	logic           new_bit;

	assign col_w = col_q[CW-1:0];
	assign row_w = row_q[RW-1:0];
	assign lc = (col_w == '0) ? CMAX : col_w - CW'(1);
	assign rc = (col_w == CMAX) ? '0 : col_w + CW'(1);
	assign ur = (row_w == '0) ? RMAX : row_w - RW'(1);
	assign dr = (row_w == RMAX) ? '0 : row_w + RW'(1);

	assign t_neg = temp_q[14];
	assign tabs = t_neg ? 15'(-temp_q) : temp_q;
	assign s_bit = rowd_q[col_w];
	assign dn_bit = rdata[col_w];
	assign nneg = 3'(rowd_q[lc]) + 3'(rowd_q[rc]) + 3'(up_q) + 3'(dn_bit);
	assign sum = 4'sd4 - signed'({nneg, 1'b0});
	assign h2 = 19'(signed'({field_q, 1'b0}));
	assign cterm = 19'(sum) <<< 13;
	assign e_val = (s_bit ? -h2 : h2) + ((t_neg ^ s_bit) ? -cterm : cterm);

	assign y = {x_q, 8'd0};
	assign p_new = 33'h1_0000_0000 - 33'(y) + 33'(y2_q >> 1) - 33'(prod[63:33]);
	assign rem_sh = {rem_q, nb_q[19]};

	always_comb begin
		case (state_q)
			ST_RDC: raddr = row_w;
			ST_RDU: raddr = ur;
			ST_RDD: raddr = dr;
			default: raddr = row_w;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = 32'(y);
				mul_b = 32'(y);
			end
			ST_M2: begin
				mul_a = prod[63:32];
				mul_b = 32'(y);
			end
			ST_M3: begin
				mul_a = {1'b0, prod[63:33]};
				mul_b = RECIP_THREE;
			end
			ST_SQ: begin
				mul_a = p_q;
				mul_b = p_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		case (act_q)
			ACT_LOAD: new_bit = ld_q;
			ACT_FLIP: new_bit = s_bit ^ flip_q;
			default:  new_bit = s_bit;
		endcase
		wdata = rowd_q;
		wdata[col_w] = new_bit;
		if (state_q == ST_CLR)
			wdata = '0;
	end

	assign we = (state_q == ST_CLR) || (state_q == ST_WR && (!out_valid_q || out_ready));
	assign waddr = (state_q == ST_CLR) ? clr_q : row_w;

	ims_lattice #(.W(LATTICE_WIDTH), .H(LATTICE_HEIGHT), .RW(RW)) u_lattice (
		.clk(clk), .raddr(raddr), .we(we), .waddr(waddr), .wdata(wdata), .rdata_q(rdata)
	);

	ims_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod));

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= TEMP_RESET;
			field_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TEMPERATURE)
				temp_q <= cfg_data;
			else if (cfg_index == REG_FIELD)
				field_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			out_valid_q <= (state_q == ST_WR && (!out_valid_q || out_ready)) ||
				(out_valid_q && !out_ready);
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == RMAX)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MOD;
				end
				ST_MOD: begin
					if ({1'b0, col_q} < WV && {1'b0, row_q} < HV)
						state_q <= ST_RDC;
				end
				ST_RDC: state_q <= ST_RDU;
				ST_RDU: state_q <= ST_RDD;
				ST_RDD: state_q <= ST_EVAL;
				ST_EVAL: begin
					cnt_q <= '0;
					if (act_q != ACT_FLIP || e_val <= 0 || temp_q == '0 ||
						20'(e_val) >= {1'b0, tabs, 4'd0})
						state_q <= ST_WR;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DIV_STEPS - 1))
						state_q <= ST_M1;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_P;
				ST_P: begin
					cnt_q <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: state_q <= ST_SQW;
				ST_SQW: begin
					cnt_q <= cnt_q + 5'd1;
					state_q <= (cnt_q == 5'(SQ_STEPS - 1)) ? ST_CMP : ST_SQ;
				end
				ST_CMP: state_q <= ST_WR;
				ST_WR: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q <= in_data.action;
				col_q <= CXW'(in_data.site_col);
				row_q <= RXW'(in_data.site_row);
				rnd_q <= in_data.random_fraction;
				ld_q <= in_data.load_spin;
				flip_q <= 1'b0;
			end
			ST_MOD: begin
				if ({1'b0, col_q} >= WV)
					col_q <= CXW'({1'b0, col_q} - WV);
				if ({1'b0, row_q} >= HV)
					row_q <= RXW'({1'b0, row_q} - HV);
			end
			ST_RDU: rowd_q <= rdata;
			ST_RDD: up_q <= rdata[col_w];
			ST_EVAL: begin
				flip_q <= (act_q == ACT_FLIP) && (e_val <= 0);
				rem_q <= 16'(e_val[16:4]);
				nb_q <= {e_val[3:0], 16'd0};
			end
			ST_DIV: begin
				nb_q <= {nb_q[18:0], 1'b0};
				if (rem_sh >= {2'b0, tabs}) begin
					rem_q <= 16'(rem_sh - {2'b0, tabs});
					x_q <= {x_q[18:0], 1'b1};
				end else begin
					rem_q <= rem_sh[15:0];
					x_q <= {x_q[18:0], 1'b0};
				end
			end
			ST_M2: y2_q <= prod[63:32];
			ST_P: p_q <= p_new[32] ? 32'hFFFF_FFFF : p_new[31:0];
			ST_SQW: p_q <= prod[63:32];
			ST_CMP: flip_q <= p_q[31:16] > rnd_q;
			ST_WR: begin
				if (!out_valid_q || out_ready) begin
					out_q.spin_now <= new_bit;
					out_q.flipped <= flip_q;
				end
			end
			default: ;
		endcase
	end

	`IMS_ASSERT_NEVER(a_ready_idle, clk, arst_n, in_ready && state_q != ST_IDLE)
	`IMS_ASSERT_IMPL(a_div_bound, clk, arst_n, state_q == ST_DIV, cnt_q < 5'(DIV_STEPS))
	`IMS_ASSERT_IMPL(a_clr_block, clk, arst_n, state_q == ST_CLR, !in_ready && !out_valid_q)
endmodule
